>>> sv/bta_pkg.sv
// Package for the boundary-tag heap allocator: opcodes, field widths and
// allocation constants. No dependencies.
`timescale 1ns / 1ps
package bta_pkg;
    localparam int OPCODE_W     = 2;
    localparam int REQ_W        = 16;
    localparam int ADDR_W       = 14;
    localparam int CFG_W        = 11;
    localparam int WANT_W       = 13;
    localparam int GRAN_SHIFT   = 4;
    localparam int MIN_PAYLOAD  = 16;
    localparam int SPLIT_SLACK  = 2;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
    localparam int MIN_GRANULES = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;
endpackage

>>> sv/bta_if.sv
// Request and response channel interfaces of the heap allocator.
// Depends on bta_pkg.
`timescale 1ns / 1ps
interface bta_req_if import bta_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [REQ_W-1:0]    request_bytes;
    logic [ADDR_W-1:0]   block_address;
    modport source (output valid, opcode, request_bytes, block_address, input ready);
    modport sink (input valid, opcode, request_bytes, block_address, output ready);
endinterface

interface bta_rsp_if import bta_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] payload_address;
    logic              status;
    modport source (output valid, payload_address, status, input ready);
    modport sink (input valid, payload_address, status, output ready);
endinterface

>>> sv/boundary_tag_heap_allocator_unit.sv
// Top level of the boundary-tag heap allocator: sequencer, configuration
// register and response register. Depends on bta_pkg, bta_if, bta_hdr_mem.
//
// One request is handled at a time, and the time a request takes is set by
// how fragmented the heap is. Allocate reads one block header per cycle
// while it walks the block list from the heap start, marks the block it
// takes and writes any split-off remainder in S_SPLIT. Free first walks the
// list to the named block (one header read per cycle), then merges it in
// S_FREE, or answers directly when it is not allocated; a malformed address
// answers without a walk. A new request is taken only in S_IDLE, after the
// previous one finishes, and a response that waits in the output register
// holds the sequencer. Headers live in two memories: one holds each block's
// own size and allocated bit, the other the fields of the block before it.
// Init and reset format the heap in S_FMT0 and S_FMT1, taking no request.
`timescale 1ns / 1ps
module boundary_tag_heap_allocator_unit import bta_pkg::*; #(
    parameter int HEAP_GRANULES = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    bta_req_if.sink          i_req,
    bta_rsp_if.source        o_rsp
);
    localparam int AW = (HEAP_GRANULES > 1) ? $clog2(HEAP_GRANULES) : 1;
    localparam int DW = AW + 1;
    localparam int CW = AW + WANT_W;

    typedef enum logic [2:0] {
        S_FMT0, S_FMT1, S_IDLE, S_WALK, S_FREE, S_SPLIT, S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_heap;
    logic                r_init_rsp, n_init_rsp;
    logic [AW-1:0]       r_g, n_g;
    logic [AW-1:0]       r_tgt, n_tgt;
    logic [AW-1:0]       r_have, n_have;
    logic [WANT_W-1:0]   r_want, n_want;
    logic                r_is_free, n_is_free;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic                r_res_status, n_res_status;
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_addr;
    logic                r_out_status;

    logic          cur_we, prev_we;
    logic [AW-1:0] cur_waddr, prev_waddr, cur_raddr;
    logic [DW-1:0] cur_wdata, prev_wdata, cur_rdata, prev_rdata;

    bta_hdr_mem #(.AW(AW), .DW(DW)) u_cur_mem (
        .i_clk(i_clk), .i_we(cur_we), .i_waddr(cur_waddr), .i_wdata(cur_wdata),
        .i_raddr(cur_raddr), .o_rdata(cur_rdata)
    );

    bta_hdr_mem #(.AW(AW), .DW(DW)) u_prev_mem (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_waddr), .i_wdata(prev_wdata),
        .i_raddr(r_g), .o_rdata(prev_rdata)
    );

    logic [31:0]       heap_n;
    logic [AW-1:0]     last_g;
    logic [REQ_W-1:0]  need;
    logic [REQ_W:0]    need_sum;
    logic [AW-1:0]     rd_size, p_size, nx_size;
    logic              rd_alloc, p_alloc, nx_alloc;
    logic [AW-1:0]     g_plus_size, extra, pbase, merged;
    logic [AW-1:0]     want_g;
    logic              fits;
    logic [ADDR_W-GRAN_SHIFT-1:0] addr_gr;
    logic [31:0]       free_g;
    logic              free_ok;
    logic [31:0]       gp1;

    always_comb begin
        if (32'(r_heap) < 32'(MIN_GRANULES)) heap_n = 32'(MIN_GRANULES);
        else if (32'(r_heap) > 32'(HEAP_GRANULES)) heap_n = 32'(HEAP_GRANULES);
        else heap_n = 32'(r_heap);
    end
    assign last_g = AW'(heap_n - 32'd1);

    // Granules wanted: max(request, 16) plus the header, rounded up.
    assign need     = (i_req.request_bytes > REQ_W'(MIN_PAYLOAD)) ?
                      i_req.request_bytes : REQ_W'(MIN_PAYLOAD);
    assign need_sum = {1'b0, need} + (REQ_W+1)'(31);

    assign rd_size  = cur_rdata[DW-1:1];
    assign rd_alloc = cur_rdata[0];
    assign nx_size  = cur_rdata[DW-1:1];
    assign nx_alloc = cur_rdata[0];
    assign p_size   = prev_rdata[DW-1:1];
    assign p_alloc  = prev_rdata[0];

    // Only meaningful once the request is known to fit in a block.
    assign want_g = AW'(r_want);

    assign g_plus_size = r_g + rd_size;
    assign fits  = !rd_alloc && (CW'(rd_size) >= CW'(r_want));
    assign extra = rd_size - want_g;
    assign gp1   = 32'(r_g) + 32'd1;

    assign addr_gr = i_req.block_address[ADDR_W-1:GRAN_SHIFT];
    assign free_g  = 32'(addr_gr) - 32'd1;
    assign free_ok = (i_req.block_address[GRAN_SHIFT-1:0] == '0) && (addr_gr != '0)
                     && (free_g < 32'(HEAP_GRANULES));

    assign i_req.ready = (r_state == S_IDLE);
    assign cur_raddr   = (r_state == S_WALK) ? g_plus_size : '0;

    assign pbase  = r_g - p_size;
    assign merged = r_have + (p_alloc ? '0 : p_size) + (nx_alloc ? '0 : nx_size);

    always_comb begin
        n_state      = r_state;
        n_init_rsp   = r_init_rsp;
        n_g          = r_g;
        n_tgt        = r_tgt;
        n_have       = r_have;
        n_want       = r_want;
        n_is_free    = r_is_free;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        cur_we       = 1'b0;
        prev_we      = 1'b0;
        cur_waddr    = '0;
        prev_waddr   = '0;
        cur_wdata    = '0;
        prev_wdata   = '0;
        case (r_state)
            S_FMT0: begin
                cur_we     = 1'b1;
                cur_wdata  = {last_g, 1'b0};
                prev_we    = 1'b1;
                prev_wdata = {{AW{1'b0}}, 1'b1};
                n_state    = S_FMT1;
            end
            S_FMT1: begin
                cur_we     = 1'b1;
                cur_waddr  = last_g;
                cur_wdata  = {{AW{1'b0}}, 1'b1};
                prev_we    = 1'b1;
                prev_waddr = last_g;
                prev_wdata = {last_g, 1'b0};
                n_state    = r_init_rsp ? S_DONE : S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_res_addr   = '0;
                    n_res_status = 1'b0;
                    n_g          = '0;
                    n_want       = need_sum[REQ_W:GRAN_SHIFT];
                    n_tgt        = AW'(free_g);
                    case (t_opcode'(i_req.opcode))
                        OP_INIT: begin
                            n_init_rsp = 1'b1;
                            n_state    = S_FMT0;
                        end
                        OP_ALLOC: begin
                            n_is_free = 1'b0;
                            n_state   = S_WALK;
                        end
                        OP_FREE: begin
                            n_is_free = 1'b1;
                            n_state   = free_ok ? S_WALK : S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_WALK: begin
                n_have = rd_size;
                if (rd_size == '0) begin
                    // Reached the terminator.
                    n_res_status = !r_is_free;
                    n_state      = S_DONE;
                end else if (r_is_free) begin
                    if (r_g == r_tgt) begin
                        // Reads of the next header and this block's prev fields
                        // are in flight.
                        n_state = rd_alloc ? S_FREE : S_DONE;
                    end else begin
                        n_g = g_plus_size;
                    end
                end else if (fits) begin
                    n_res_addr = {gp1[ADDR_W-GRAN_SHIFT-1:0], 4'b0000};
                    cur_we     = 1'b1;
                    cur_waddr  = r_g;
                    prev_we    = 1'b1;
                    if (CW'(extra) > CW'(SPLIT_SLACK)) begin
                        cur_wdata  = {want_g, 1'b1};
                        prev_waddr = r_g + want_g;
                        prev_wdata = {want_g, 1'b1};
                        n_state    = S_SPLIT;
                    end else begin
                        cur_wdata  = {rd_size, 1'b1};
                        prev_waddr = g_plus_size;
                        prev_wdata = {rd_size, 1'b1};
                        n_state    = S_DONE;
                    end
                end else begin
                    n_g = g_plus_size;
                end
            end
            S_SPLIT: begin
                cur_we     = 1'b1;
                cur_waddr  = r_g + want_g;
                cur_wdata  = {AW'(r_have - want_g), 1'b0};
                prev_we    = 1'b1;
                prev_waddr = r_g + r_have;
                prev_wdata = {AW'(r_have - want_g), 1'b0};
                n_state    = S_DONE;
            end
            S_FREE: begin
                cur_we     = 1'b1;
                cur_waddr  = p_alloc ? r_g : pbase;
                cur_wdata  = {merged, 1'b0};
                prev_we    = 1'b1;
                prev_waddr = (p_alloc ? r_g : pbase) + merged;
                prev_wdata = {merged, 1'b0};
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FMT0;
            r_heap      <= CFG_RESET;
            r_init_rsp  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_init_rsp <= (r_state == S_DONE) ? 1'b0 : n_init_rsp;
            if (i_cfg_we) begin
                r_heap <= i_cfg_wdata;
            end
            if (r_state == S_DONE && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid  <= 1'b1;
                r_out_addr   <= r_res_addr;
                r_out_status <= r_res_status;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_g          <= n_g;
        r_tgt        <= n_tgt;
        r_have       <= n_have;
        r_want       <= n_want;
        r_is_free    <= n_is_free;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.payload_address = r_out_addr;
    assign o_rsp.status          = r_out_status;
endmodule

>>> sv/bta_hdr_mem.sv
// Synchronous header memory, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module bta_hdr_mem #(
    parameter int AW = 10,
    parameter int DW = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
